@@ rtl/hcbp_pkg.sv @@
package hcbp_pkg;

  // table geometry
  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned SYMBOL_COUNT = 256;
  localparam int unsigned ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // port field widths
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned SYMBOL_W  = 8;
  localparam int unsigned CODE_W    = 32;
  localparam int unsigned LENGTH_W  = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PEND_W    = BYTE_W - 1;

  // stored length, accumulator and bit count widths
  localparam int unsigned LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned ACC_W = MAX_CODE_LEN + PEND_W;
  localparam int unsigned TOT_W = $clog2(ACC_W + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SEL_CODE       = 2'd0,
    SEL_FLUSH_DATA = 2'd1,
    SEL_PAD        = 2'd2
  } emit_sel_e;

  typedef struct packed {
    logic      tbl_wr;
    logic      rd_en;
    logic      acc_load;
    logic      emit;
    emit_sel_e sel;
    logic      last;
    logic      clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic lookup_empty;
    logic new_ge8;
    logic pend_nz;
    logic total_lt8;
    logic emit_last;
  } sts_t;

endpackage

@@ rtl/huffman_code_bit_packer.sv @@
// Huffman encoder back end. A load transaction (action 0) writes one symbol's
// right-aligned code and its length (saturated to 32) into a 256-entry code
// table. An encode transaction (action 1) completes n bytes, n from 0 to 4:
// it does the registered read of the code table, then appends the code to the
// bit accumulator, then emits each completed byte through the single output
// register. A flush transaction (action 2) emits the zero-padded partial byte
// and then the padding count byte when a partial byte is pending, and only the
// padding count byte without. An output stall holds byte emission. Bytes carry
// the earliest bit at bit 7, last marks the final byte of a transaction, and
// the padding count byte sets is_padding_count. Encoding a symbol whose entry
// was never loaded gives undefined output. The table has no reset; the
// accumulator clears on reset.
module huffman_code_bit_packer (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // input transaction channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hcbp_pkg::ACTION_W-1:0]   action_i,
  input  logic [hcbp_pkg::SYMBOL_W-1:0]   symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0]     code_value_i,
  input  logic [hcbp_pkg::LENGTH_W-1:0]   code_length_i,

  // output byte channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hcbp_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                            is_padding_count_o,
  output logic                            last_o
);

  // command and status between sequencer and datapath
  hcbp_pkg::cmd_t cmd;
  hcbp_pkg::sts_t sts;

  // sequencer: decodes the action, walks through lookup and byte emission
  hcbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: code table, bit accumulator and output register
  hcbp_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .symbol_i           (symbol_i),
    .code_value_i       (code_value_i),
    .code_length_i      (code_length_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_byte_o         (out_byte_o),
    .is_padding_count_o (is_padding_count_o),
    .last_o             (last_o)
  );

endmodule

@@ rtl/hcbp_dp.sv @@
module hcbp_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hcbp_pkg::cmd_t                   cmd_i,
  output hcbp_pkg::sts_t                   sts_o,
  input  logic [hcbp_pkg::SYMBOL_W-1:0]    symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0]      code_value_i,
  input  logic [hcbp_pkg::LENGTH_W-1:0]    code_length_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [hcbp_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                             is_padding_count_o,
  output logic                             last_o
);

  localparam int unsigned ENTRY_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

  logic [ENTRY_W-1:0]               mem [hcbp_pkg::SYMBOL_COUNT];
  logic [ENTRY_W-1:0]               rd_q;
  logic                             sym_ok_q;
  logic                             sym_ok;
  logic [hcbp_pkg::ADDR_W-1:0]      addr;
  logic [hcbp_pkg::LEN_W-1:0]       len_sat;
  logic [hcbp_pkg::CODE_W-1:0]      code_masked;
  logic [hcbp_pkg::LEN_W-1:0]       rd_len;
  logic [hcbp_pkg::CODE_W-1:0]      rd_code;

  logic [hcbp_pkg::ACC_W-1:0]       acc_q, acc_d, acc_new;
  logic [hcbp_pkg::TOT_W-1:0]       total_q, total_d, total_new, shamt;
  logic [2:0]                       count;
  logic [hcbp_pkg::PEND_W-1:0]      pend_bits;
  logic [hcbp_pkg::BYTE_W-1:0]      byte_sel;

  logic                             out_valid_q;
  logic [hcbp_pkg::BYTE_W-1:0]      out_byte_q;
  logic                             out_pad_q;
  logic                             out_last_q;

  assign sym_ok = ({1'b0, symbol_i} < 9'(hcbp_pkg::SYMBOL_COUNT));
  assign addr   = symbol_i[hcbp_pkg::ADDR_W-1:0];

  // saturate the length and drop code bits above it
  always_comb begin
    if (int'(code_length_i) > int'(hcbp_pkg::MAX_CODE_LEN)) begin
      len_sat = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
    end else begin
      len_sat = hcbp_pkg::LEN_W'(code_length_i);
    end
    for (int i = 0; i < int'(hcbp_pkg::CODE_W); i++) begin
      code_masked[i] = code_value_i[i] && (int'(len_sat) > i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && sym_ok) begin
      mem[addr] <= {len_sat, code_masked};
    end
    if (cmd_i.rd_en) begin
      rd_q     <= mem[addr];
      sym_ok_q <= sym_ok;
    end
  end

  assign rd_len  = rd_q[ENTRY_W-1:hcbp_pkg::CODE_W];
  assign rd_code = rd_q[hcbp_pkg::CODE_W-1:0];

  // pending bits live in the low part of the accumulator
  assign count     = total_q[2:0];
  assign pend_bits = acc_q[hcbp_pkg::PEND_W-1:0]
                     & hcbp_pkg::PEND_W'((8'd1 << count) - 8'd1);
  assign acc_new   = (hcbp_pkg::ACC_W'(pend_bits) << rd_len) | hcbp_pkg::ACC_W'(rd_code);
  assign total_new = total_q + hcbp_pkg::TOT_W'(rd_len);
  assign shamt     = total_q - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W);

  always_comb begin
    case (cmd_i.sel)
      hcbp_pkg::SEL_CODE: begin
        byte_sel = hcbp_pkg::BYTE_W'(acc_q >> shamt);
      end
      hcbp_pkg::SEL_FLUSH_DATA: begin
        byte_sel = hcbp_pkg::BYTE_W'({1'b0, pend_bits} << (4'd8 - {1'b0, count}));
      end
      hcbp_pkg::SEL_PAD: begin
        byte_sel = (count == 3'd0) ? '0 : hcbp_pkg::BYTE_W'(4'd8 - {1'b0, count});
      end
      default: begin
        byte_sel = '0;
      end
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    total_d = total_q;
    if (cmd_i.acc_load) begin
      acc_d   = acc_new;
      total_d = total_new;
    end else if (cmd_i.clear) begin
      acc_d   = '0;
      total_d = '0;
    end else if (cmd_i.emit && cmd_i.sel == hcbp_pkg::SEL_CODE) begin
      total_d = shamt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      total_q <= '0;
    end else begin
      acc_q   <= acc_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= byte_sel;
      out_pad_q  <= (cmd_i.sel == hcbp_pkg::SEL_PAD);
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_byte_q;
  assign is_padding_count_o = out_pad_q;
  assign last_o             = out_last_q;

  assign sts_o.out_free     = !out_valid_q || !out_stall_i;
  assign sts_o.lookup_empty = !sym_ok_q || (rd_len == '0);
  assign sts_o.new_ge8      = (total_new >= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
  assign sts_o.pend_nz      = (count != 3'd0);
  assign sts_o.total_lt8    = (total_q < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
  assign sts_o.emit_last    = (shamt < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("byte emitted into an occupied output register");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (total_q == '0))
    else $error("accumulator not empty after flush");

  a_code_emit_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.sel == hcbp_pkg::SEL_CODE)
      |-> (total_q >= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W)))
    else $error("code byte emitted with fewer than eight bits held");

endmodule

@@ rtl/hcbp_ctrl.sv @@
module hcbp_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hcbp_pkg::ACTION_W-1:0]   action_i,
  input  hcbp_pkg::sts_t                  sts_i,
  output hcbp_pkg::cmd_t                  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EMIT,
    S_FLUSH_DATA,
    S_FLUSH_PAD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{tbl_wr: 1'b0, rd_en: 1'b0, acc_load: 1'b0, emit: 1'b0,
                sel: hcbp_pkg::SEL_CODE, last: 1'b0, clear: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            hcbp_pkg::ACT_LOAD: begin
              cmd_o.tbl_wr = 1'b1;
            end
            hcbp_pkg::ACT_ENCODE: begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_LOOKUP;
            end
            hcbp_pkg::ACT_FLUSH: begin
              state_d = sts_i.pend_nz ? S_FLUSH_DATA : S_FLUSH_PAD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        if (sts_i.lookup_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.acc_load = 1'b1;
          state_d        = sts_i.new_ge8 ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = hcbp_pkg::SEL_CODE;
          cmd_o.last = sts_i.emit_last;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH_DATA: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = hcbp_pkg::SEL_FLUSH_DATA;
          state_d    = S_FLUSH_PAD;
        end
      end
      S_FLUSH_PAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.sel   = hcbp_pkg::SEL_PAD;
          cmd_o.last  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_partial_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> sts_i.total_lt8)
    else $error("whole byte left in accumulator while idle");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("transaction continued after its last byte");

  a_flush_data_then_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH_DATA && cmd_o.emit) |=> (state_q == S_FLUSH_PAD))
    else $error("partial byte not followed by padding count");

endmodule
